[rtl/mrwt_pkg.sv]
// ----------------------------------------------------------------------------
// mrwt_pkg
// Shared widths, verdict codes and sequencer state type for the
// Miller-Rabin witness tester.
// ----------------------------------------------------------------------------
`default_nettype none

package mrwt_pkg;

  // Fixed field widths on the stream ports
  localparam int FIELD_BITS   = 62;
  localparam int IN_DATA_BITS = 128;  // two 62-bit fields, padded to bytes
  localparam int OUT_DATA_BITS = 8;

  // Per-round verdict
  typedef enum logic [1:0] {
    ST_PRIME     = 2'd0,
    ST_COMPOSITE = 2'd1,
    ST_BAD_BASE  = 2'd2
  } round_status_t;

  // Sequencer states, one-hot
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_STRIP  = 9'b000000010,
    S_POW    = 9'b000000100,
    S_PMUL   = 9'b000001000,
    S_PSQ    = 9'b000010000,
    S_CHK    = 9'b000100000,
    S_SQLOOP = 9'b001000000,
    S_SQWAIT = 9'b010000000,
    S_DONE   = 9'b100000000
  } mr_state_t;

endpackage : mrwt_pkg

`default_nettype wire

[rtl/miller_rabin_witness_test.sv]
// ----------------------------------------------------------------------------
// miller_rabin_witness_test
// One Miller-Rabin round per input transfer, with a running composite flag
// that gives the overall verdict on the last witness of a candidate.
// ----------------------------------------------------------------------------
// Each input transfer carries a candidate n, a witness base w and a
// last-witness mark (tlast); each produces exactly one output transfer with
// the round verdict (0 probably prime, 1 composite, 2 witness out of range),
// the running composite flag and an echo of the mark. Candidates below 2 and
// even candidates other than 2 are composite at once; a witness of 0 or one
// at least n is flagged and does not touch the running flag. Only the low
// NUM_BITS bits of candidate and witness are used. One item is worked at a
// time. Time per item is set by the single bit-serial modular multiplier:
// a round needs bitlen(d) + popcount(d) + squarings products, where
// n-1 = d * 2^r, plus the steps that strip the factors of two from n-1.
// Trivial and out-of-range cases go to the result without the multiplier.
// At 62 bits the worst-case round (n = 2^62-1) needs 122 products.
// A finished result sits in the output register while the next transfer is
// accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module miller_rabin_witness_test
  import mrwt_pkg::*;
#(
  parameter int NUM_BITS = 62
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // input stream
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  // [61:0] candidate, [123:62] witness, [127:124] zero
  input  wire logic [IN_DATA_BITS-1:0]  s_axis_tdata,
  input  wire logic                     s_axis_tlast,   // last_witness
  // output stream
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // [1:0] round_status, [2] overall_composite, [7:3] zero
  output logic [OUT_DATA_BITS-1:0]      m_axis_tdata,
  output logic                          m_axis_tlast    // final_round
);

  localparam int RW = $clog2(NUM_BITS);

  mr_state_t state;

  logic [NUM_BITS-1:0] n;        // candidate
  logic [NUM_BITS-1:0] nm1;      // candidate - 1
  logic [NUM_BITS-1:0] d;        // odd part of n-1, then exponent shifter
  logic [NUM_BITS-1:0] sq;       // running square of the base
  logic [NUM_BITS-1:0] x;        // power result, then squaring chain
  logic [RW-1:0]       r;        // power of two in n-1
  logic [RW-1:0]       i;        // squarings done + 1
  logic                last;
  round_status_t       status;
  logic                composite_seen;

  logic [NUM_BITS-1:0] in_n;
  logic [NUM_BITS-1:0] in_w;
  logic                trivial;
  logic                bad_base;
  logic                in_fire;
  logic                out_free;
  logic                composite_next;

  // multiplier hookup
  logic                mm_start;
  logic [NUM_BITS-1:0] mm_a;
  logic [NUM_BITS-1:0] mm_b;
  logic                mm_busy;
  logic                mm_done;
  logic [NUM_BITS-1:0] mm_product;

  assign in_n = s_axis_tdata[NUM_BITS-1:0];
  assign in_w = s_axis_tdata[FIELD_BITS+NUM_BITS-1:FIELD_BITS];

  // n < 2, or even and not 2
  assign trivial  = (in_n[NUM_BITS-1:1] == '0) ||
                    (!in_n[0] && in_n != NUM_BITS'(2));
  assign bad_base = (in_w == '0) || (in_w >= in_n);

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign composite_next = composite_seen || (status == ST_COMPOSITE);

  mrwt_modmul #(
    .NUM_BITS (NUM_BITS)
  ) u_modmul (
    .clk     (clk),
    .rst     (rst),
    .start   (mm_start),
    .a       (mm_a),
    .b       (mm_b),
    .n       (n),
    .busy    (mm_busy),
    .done    (mm_done),
    .product (mm_product)
  );

  // multiplier launches: result*sq, sq*sq, or x*x
  always_comb begin
    mm_start = 1'b0;
    mm_a     = sq;
    mm_b     = sq;
    case (state)
      S_POW: begin
        if (d != '0) begin
          mm_start = 1'b1;
          if (d[0]) begin
            mm_a = x;
          end
        end
      end
      S_PMUL: begin
        mm_start = mm_done;
      end
      S_SQLOOP: begin
        if (i < r) begin
          mm_start = 1'b1;
          mm_a     = x;
          mm_b     = x;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      composite_seen <= 1'b0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (trivial) begin
              state <= S_DONE;
            end else if (bad_base) begin
              state <= S_DONE;
            end else begin
              state <= S_STRIP;
            end
          end
        end
        S_STRIP: begin
          if (d[0]) begin
            state <= S_POW;
          end
        end
        S_POW: begin
          if (d == '0) begin
            state <= S_CHK;
          end else if (d[0]) begin
            state <= S_PMUL;
          end else begin
            state <= S_PSQ;
          end
        end
        S_PMUL: begin
          if (mm_done) begin
            state <= S_PSQ;
          end
        end
        S_PSQ: begin
          if (mm_done) begin
            state <= S_POW;
          end
        end
        S_CHK: begin
          if (x == NUM_BITS'(1) || x == nm1) begin
            state <= S_DONE;
          end else begin
            state <= S_SQLOOP;
          end
        end
        S_SQLOOP: begin
          if (i < r) begin
            state <= S_SQWAIT;
          end else begin
            state <= S_DONE;
          end
        end
        S_SQWAIT: begin
          if (mm_done) begin
            if (mm_product == nm1 || mm_product == NUM_BITS'(1)) begin
              state <= S_DONE;
            end else begin
              state <= S_SQLOOP;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            state          <= S_IDLE;
            composite_seen <= last ? 1'b0 : composite_next;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          n    <= in_n;
          nm1  <= in_n - NUM_BITS'(1);
          d    <= in_n - NUM_BITS'(1);
          sq   <= in_w;
          x    <= NUM_BITS'(1);
          r    <= '0;
          last <= s_axis_tlast;
          if (trivial) begin
            status <= ST_COMPOSITE;
          end else if (bad_base) begin
            status <= ST_BAD_BASE;
          end else begin
            status <= ST_PRIME;
          end
        end
      end
      S_STRIP: begin
        if (!d[0]) begin
          d <= d >> 1;
          r <= r + RW'(1);
        end
      end
      S_PMUL: begin
        if (mm_done) begin
          x <= mm_product;
        end
      end
      S_PSQ: begin
        if (mm_done) begin
          sq <= mm_product;
          d  <= d >> 1;
        end
      end
      S_CHK: begin
        i <= RW'(1);
        if (x == NUM_BITS'(1) || x == nm1) begin
          status <= ST_PRIME;
        end
      end
      S_SQLOOP: begin
        if (!(i < r)) begin
          status <= ST_COMPOSITE;
        end
      end
      S_SQWAIT: begin
        if (mm_done) begin
          x <= mm_product;
          i <= i + RW'(1);
          if (mm_product == nm1) begin
            status <= ST_PRIME;
          end else if (mm_product == NUM_BITS'(1)) begin
            status <= ST_COMPOSITE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          m_axis_tdata <= {{(OUT_DATA_BITS-3){1'b0}}, composite_next, status};
          m_axis_tlast <= last;
        end
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // a new item is only taken with the multiplier at rest
  a_idle_mm_quiet: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !mm_busy && !mm_done)
    else $error("input accepted while multiplier active");

  // products only come back while the sequencer waits for one
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mm_done |-> (state == S_PMUL || state == S_PSQ || state == S_SQWAIT))
    else $error("multiplier result with no waiting state");

  // never launch the multiplier while it is running
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    mm_start |-> !mm_busy)
    else $error("multiplier restarted while busy");

  // the running flag is clear after a final-round result is produced
  a_flag_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free && last) |=> !composite_seen)
    else $error("composite flag not cleared after last round");

endmodule : miller_rabin_witness_test

`default_nettype wire

[rtl/mrwt_modmul.sv]
// ----------------------------------------------------------------------------
// mrwt_modmul
// Bit-serial modular multiplier: product = a * b mod n, one bit of b per
// cycle, shift-and-add with a conditional subtract on each step.
// ----------------------------------------------------------------------------
`default_nettype none

module mrwt_modmul #(
  parameter int NUM_BITS = 62
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [NUM_BITS-1:0] a,        // a < n
  input  wire logic [NUM_BITS-1:0] b,        // b < n
  input  wire logic [NUM_BITS-1:0] n,        // held stable while busy
  output logic                     busy,
  output logic                     done,     // one-cycle pulse, product valid
  output logic [NUM_BITS-1:0]      product
);

  localparam int CW = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] acc;
  logic [NUM_BITS-1:0] addend;
  logic [NUM_BITS-1:0] bsh;
  logic [CW-1:0]       cnt;

  logic [NUM_BITS:0]   sum;
  logic [NUM_BITS:0]   dbl;
  logic [NUM_BITS-1:0] acc_next;
  logic [NUM_BITS-1:0] addend_next;

  // both operands stay below n, so sums stay below 2n
  always_comb begin
    sum = {1'b0, acc} + {1'b0, addend};
    dbl = {addend, 1'b0};
    if (sum >= {1'b0, n}) begin
      acc_next = NUM_BITS'(sum - {1'b0, n});
    end else begin
      acc_next = sum[NUM_BITS-1:0];
    end
    if (dbl >= {1'b0, n}) begin
      addend_next = NUM_BITS'(dbl - {1'b0, n});
    end else begin
      addend_next = dbl[NUM_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      addend <= a;
      bsh    <= b;
      cnt    <= CW'(NUM_BITS);
    end else if (busy) begin
      if (bsh[0]) begin
        acc <= acc_next;
      end
      addend <= addend_next;
      bsh    <= bsh >> 1;
      cnt    <= cnt - CW'(1);
    end
  end

  assign product = acc;

endmodule : mrwt_modmul

`default_nettype wire

[test/mrwt_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mrwt_checker
// Watches both stream ports of the witness tester. It predicts each round's
// verdict and running composite flag, and compares them with the results.
// ----------------------------------------------------------------------------
module mrwt_checker
  import mrwt_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_axis_tvalid,
  input  wire logic                    s_axis_tready,
  // [61:0] candidate, [123:62] witness, [127:124] zero
  input  wire logic [IN_DATA_BITS-1:0] s_axis_tdata,
  input  wire logic                    s_axis_tlast,   // last_witness
  input  wire logic                    m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  // [1:0] round_status, [2] overall_composite, [7:3] zero
  input  wire logic [OUT_DATA_BITS-1:0] m_axis_tdata,
  input  wire logic                    m_axis_tlast,   // final_round
  output int                           fail_count,
  output int                           outstanding
);

  localparam logic [63:0] VALUE_MASK = (64'd1 << FIELD_BITS) - 64'd1;

  typedef struct {
    round_status_t status;
    logic          overall;
    logic          final_flag;
  } verdict_t;

  verdict_t verdict_q[$];
  logic     composite_seen;

  // shift-and-add product mod n; operands below n < 2^62
  function automatic logic [63:0] mulmod(input logic [63:0] a, input logic [63:0] b,
                                         input logic [63:0] n);
    logic [63:0] acc;
    logic [63:0] addend;
    logic [63:0] rest;
    acc    = '0;
    addend = a;
    rest   = b;
    while (rest != 0) begin
      if (rest[0]) begin
        acc = acc + addend;
        if (acc >= n) acc = acc - n;
      end
      addend = addend + addend;
      if (addend >= n) addend = addend - n;
      rest = rest >> 1;
    end
    return acc;
  endfunction

  function automatic logic [63:0] powmod(input logic [63:0] base, input logic [63:0] e,
                                         input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] sq;
    logic [63:0] rest;
    res  = 64'd1 % n;
    sq   = base % n;
    rest = e;
    while (rest != 0) begin
      if (rest[0]) res = mulmod(res, sq, n);
      sq   = mulmod(sq, sq, n);
      rest = rest >> 1;
    end
    return res;
  endfunction

  // n odd >= 3 or n == 2, 1 <= w < n
  function automatic logic base_proves_composite(input logic [63:0] n, input logic [63:0] w);
    logic [63:0] nm1;
    logic [63:0] d;
    logic [63:0] x;
    int          r;
    nm1 = n - 64'd1;
    d   = nm1;
    r   = 0;
    while (d != 0 && !d[0]) begin
      d = d >> 1;
      r++;
    end
    x = powmod(w, d, n);
    if (x == 64'd1 || x == nm1) return 1'b0;
    for (int i = 1; i < r; i++) begin
      x = mulmod(x, x, n);
      if (x == nm1) return 1'b0;
      if (x == 64'd1) return 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic round_status_t predict_round(input logic [63:0] n, input logic [63:0] w);
    if (n < 2 || (n != 2 && !n[0])) return ST_COMPOSITE;
    if (w == 0 || w >= n) return ST_BAD_BASE;
    return base_proves_composite(n, w) ? ST_COMPOSITE : ST_PRIME;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    verdict_t    want;
    logic [63:0] n;
    logic [63:0] w;
    if (rst) begin
      composite_seen = 1'b0;
      verdict_q.delete();
      outstanding = 0;
    end else begin
      // result side first: it can never belong to this cycle's input transfer
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result transfer with nothing pending", 64'(m_axis_tdata),
                          64'd0);
        end else begin
          want = verdict_q.pop_front();
          if (m_axis_tdata[1:0] != want.status)
            report_mismatch("round_status", 64'(m_axis_tdata[1:0]), 64'(want.status));
          if (m_axis_tdata[2] != want.overall)
            report_mismatch("overall_composite", 64'(m_axis_tdata[2]), 64'(want.overall));
          if (m_axis_tlast != want.final_flag)
            report_mismatch("final_round", 64'(m_axis_tlast), 64'(want.final_flag));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        n = 64'(s_axis_tdata[FIELD_BITS-1:0]) & VALUE_MASK;
        w = 64'(s_axis_tdata[2*FIELD_BITS-1:FIELD_BITS]) & VALUE_MASK;
        want.status = predict_round(n, w);
        if (want.status == ST_COMPOSITE) composite_seen = 1'b1;
        want.overall    = composite_seen;
        want.final_flag = s_axis_tlast;
        if (s_axis_tlast) composite_seen = 1'b0;
        verdict_q.push_back(want);
      end
      outstanding = verdict_q.size();
    end
  end

endmodule : mrwt_checker

[test/tb_miller_rabin_witness_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_miller_rabin_witness_test
// Stimulus and verdict for the Miller-Rabin witness tester: directed corner
// rounds, then random witness sequences per candidate with random idling on
// both ports. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_miller_rabin_witness_test;
  import mrwt_pkg::*;

  localparam logic [63:0] MASK62    = (64'd1 << FIELD_BITS) - 64'd1;
  localparam logic [63:0] BIG_PRIME = 64'd4611686018427387847;  // 2^62 - 57
  localparam logic [63:0] M61       = 64'd2305843009213693951;  // 2^61 - 1

  localparam logic [63:0] SMALL_PRIMES [8] = '{
    64'd3, 64'd5, 64'd7, 64'd13, 64'd101, 64'd65521, 64'd104729, 64'd999983
  };
  // Carmichael numbers and strong pseudoprimes: the interesting liars
  localparam logic [63:0] LIARS [8] = '{
    64'd561, 64'd1105, 64'd1729, 64'd2047, 64'd2465, 64'd3277, 64'd8321, 64'd8911
  };
  localparam logic [63:0] WIDE_PRIMES [3] = '{M61, BIG_PRIME, 64'd2147483647};

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;   // [61:0] cand, [123:62] witness
  logic                     s_axis_tlast = 1'b0; // last_witness
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;        // [1:0] status, [2] overall
  logic                     m_axis_tlast;        // final_round
  int                       fail_count;
  int                       outstanding;
  // high during a stretch where neither side idles
  logic                     steady = 1'b0;

  miller_rabin_witness_test #(.NUM_BITS(FIELD_BITS)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  mrwt_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side: stalls about 29% of cycles, never during the steady stretch.
  always @(negedge clk) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 29);
  end

  // One round. Entered just after a falling edge; returns just after the
  // falling edge that follows its transfer, so tvalid is set once per step.
  task automatic send_round(input logic [63:0] cand, input logic [63:0] wit,
                            input logic last);
    while (!steady && $urandom_range(99) < 29) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {4'b0000, wit[FIELD_BITS-1:0], cand[FIELD_BITS-1:0]};
    s_axis_tlast  = last;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  initial begin
    int          items;
    int          kind;
    int          rounds;
    int          pick;
    int          width;
    logic        drop_last;
    logic [63:0] n;
    logic [63:0] w;
    logic [63:0] r64;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // ---- directed rounds ----
    // trivial candidates: zero, one, even with the widest witness
    send_round(64'd0, 64'd0, 1'b0);
    send_round(64'd1, 64'd5, 1'b1);
    send_round(MASK62 - 64'd1, MASK62, 1'b1);
    send_round(64'd4, 64'd3, 1'b1);
    // two is prime; its only valid witness is one
    send_round(64'd2, 64'd1, 1'b1);
    send_round(64'd2, 64'd2, 1'b1);
    // witness out of range: zero and equal to n, flag untouched
    send_round(64'd3, 64'd2, 1'b0);
    send_round(64'd3, 64'd0, 1'b0);
    send_round(64'd3, 64'd3, 1'b1);
    // Carmichael: nontrivial square root of one, then an n-1 witness
    send_round(64'd561, 64'd2, 1'b0);
    send_round(64'd561, 64'd560, 1'b1);
    // strong pseudoprime to base 2, caught by base 3
    send_round(64'd2047, 64'd2, 1'b1);
    send_round(64'd2047, 64'd3, 1'b1);
    // witness one, and a base sharing a factor with n
    send_round(64'd1729, 64'd2, 1'b0);
    send_round(64'd1729, 64'd1, 1'b0);
    send_round(64'd1729, 64'd7, 1'b1);
    // widest odd composite, with the largest in-range witness
    send_round(MASK62, MASK62 - 64'd1, 1'b0);
    send_round(MASK62, 64'd2, 1'b1);
    // wide primes; an all-ones witness is out of range
    send_round(BIG_PRIME, 64'd2, 1'b0);
    send_round(BIG_PRIME, BIG_PRIME - 64'd1, 1'b0);
    send_round(BIG_PRIME, MASK62, 1'b1);
    send_round(M61, 64'd3, 1'b1);

    // ---- random witness sequences ----
    // Most candidates are small so the multiplier loop stays short; a few
    // use the full width. Some sequences lose their last mark, so the
    // running flag carries into the next candidate.
    items = 0;
    while (items < 78) begin
      kind = $urandom_range(19);
      r64  = {$urandom, $urandom};
      if (kind == 0) begin
        n = 64'(r64[0]);
      end else if (kind <= 2) begin
        n = r64 & MASK62 & ~64'd1;
      end else if (kind <= 5) begin
        n = SMALL_PRIMES[$urandom_range(7)];
      end else if (kind <= 7) begin
        n = LIARS[$urandom_range(7)];
      end else if (kind <= 16) begin
        width = (kind <= 13) ? $urandom_range(2, 24) : $urandom_range(25, 40);
        n = (r64 & ((64'd1 << width) - 64'd1)) | 64'd1;
      end else if (kind <= 18) begin
        n = (r64 & MASK62) | 64'd1;
      end else begin
        n = WIDE_PRIMES[$urandom_range(2)];
      end
      rounds    = $urandom_range(1, 4);
      drop_last = ($urandom_range(9) == 0);
      for (int k = 0; k < rounds; k++) begin
        steady = (items >= 40 && items < 62);
        r64    = {$urandom, $urandom};
        pick   = $urandom_range(19);
        if (n < 3 || !n[0]) begin
          w = r64 & MASK62;
        end else if (pick == 0) begin
          w = '0;
        end else if (pick == 1) begin
          w = n + (r64 % (MASK62 - n + 64'd1));   // n .. all ones
        end else begin
          w = (r64 % (n - 64'd1)) + 64'd1;
        end
        send_round(n, w, (k == rounds - 1) && !drop_last);
        items++;
      end
    end
    steady        = 1'b0;
    s_axis_tvalid = 1'b0;

    // drain, then a short tail for any stray result transfer
    while (outstanding != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("miller_rabin_witness_test: match");
    end else begin
      $display("miller_rabin_witness_test: mismatch");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #100_000_000;
    $display("miller_rabin_witness_test: mismatch");
    $finish;
  end

endmodule : tb_miller_rabin_witness_test

[filelist.f]
rtl/mrwt_pkg.sv
rtl/mrwt_modmul.sv
rtl/miller_rabin_witness_test.sv
test/mrwt_checker.sv
test/tb_miller_rabin_witness_test.sv
